// File: sv/assert_macros.svh
// Assertion macros shared by the transcoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define BTTU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define BTTU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/bttu_pkg.sv
// Shared types, constants and the UTF-8 encoder of the transcoder.
package bttu_pkg;

   localparam logic [7:0]  BOM_HIGH    = 8'hFE;
   localparam logic [7:0]  BOM_LOW     = 8'hFF;
   localparam logic [15:0] SURR_FIRST  = 16'hD800;
   localparam logic [15:0] SURR_LAST   = 16'hDFFF;
   localparam int          QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      len_m1;
   } enc_type;

   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      count_m1;
      logic            str_last;
   } job_type;

   function automatic enc_type encode_code_point(input logic [15:0] cp);
      enc_type enc;
      enc = '0;
      if (cp < 16'h0080) begin
         enc.data[0] = cp[7:0];
         enc.len_m1  = 2'd0;
      end else if (cp < 16'h0800) begin
         enc.data[0] = {3'b110, cp[10:6]};
         enc.data[1] = {2'b10, cp[5:0]};
         enc.len_m1  = 2'd1;
      end else begin
         enc.data[0] = {4'b1110, cp[15:12]};
         enc.data[1] = {2'b10, cp[11:6]};
         enc.data[2] = {2'b10, cp[5:0]};
         enc.len_m1  = 2'd2;
      end
      return enc;
   endfunction

endpackage

// File: sv/bttu_req_if.sv
// Input channel: one source byte per beat with string boundary marks.
interface bttu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       str_first;
   logic       str_last;

   modport source (output valid, output in_byte, output str_first, output str_last,
                   input ready);
   modport sink (input valid, input in_byte, input str_first, input str_last,
                 output ready);
endinterface

// File: sv/bttu_rsp_if.sv
// Result channel: one UTF-8 byte per beat with run and string end marks.
interface bttu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] utf8_byte;
   logic       run_last;
   logic       string_end;

   modport source (output valid, output utf8_byte, output run_last, output string_end,
                   input ready);
   modport sink (input valid, input utf8_byte, input run_last, input string_end,
                 output ready);
endinterface

// File: sv/bttu_front.sv
// Front end: tracks the string mode and turns input bytes into jobs of UTF-8 bytes.
`include "assert_macros.svh"

module bttu_front (
   input  logic               clock,
   input  logic               reset,
   bttu_req_if.sink           req_bus,
   output logic               push_valid,
   input  logic               push_ready,
   output bttu_pkg::job_type  push_job
);

   typedef enum logic [3:0] {
      MODE_START  = 4'b0001,
      MODE_SAW_FE = 4'b0010,
      MODE_UTF16  = 4'b0100,
      MODE_LATIN1 = 4'b1000
   } mode_type;

   mode_type          mode_ff, mode_in, mode_eff;
   logic              hv_ff, hv_in, hv_eff;
   logic [7:0]        hb_ff, hb_in;
   logic              emit;
   logic              accept;
   logic [15:0]       unit;
   bttu_pkg::enc_type enc_b, enc_w;
   bttu_pkg::job_type job;

   assign req_bus.ready = push_ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign push_valid    = req_bus.valid && emit;
   assign push_job      = job;
   assign unit          = {hb_ff, req_bus.in_byte};

   always_comb begin
      mode_eff = req_bus.str_first ? MODE_START : mode_ff;
      hv_eff   = req_bus.str_first ? 1'b0 : hv_ff;
      enc_b    = bttu_pkg::encode_code_point({8'h00, req_bus.in_byte});
      enc_w    = bttu_pkg::encode_code_point(unit);
      mode_in  = mode_eff;
      hv_in    = hv_eff;
      hb_in    = hb_ff;
      emit     = 1'b0;
      job          = '0;
      job.str_last = req_bus.str_last;
      unique case (mode_eff)
         MODE_START: begin
            if (req_bus.in_byte == bttu_pkg::BOM_HIGH && !req_bus.str_last) begin
               mode_in = MODE_SAW_FE;
            end else begin
               job.data[2:0] = enc_b.data;
               job.count_m1  = enc_b.len_m1;
               emit          = 1'b1;
               mode_in       = MODE_LATIN1;
            end
         end
         MODE_SAW_FE: begin
            if (req_bus.in_byte == bttu_pkg::BOM_LOW) begin
               mode_in = MODE_UTF16;
               hv_in   = 1'b0;
            end else begin
               job.data[0]   = 8'hC3;
               job.data[1]   = 8'hBE;
               job.data[3:2] = enc_b.data[1:0];
               job.count_m1  = 2'd2 + enc_b.len_m1;
               emit          = 1'b1;
               mode_in       = MODE_LATIN1;
            end
         end
         MODE_UTF16: begin
            if (!hv_eff) begin
               hb_in = req_bus.in_byte;
               hv_in = 1'b1;
            end else begin
               hv_in = 1'b0;
               if (unit < bttu_pkg::SURR_FIRST || unit > bttu_pkg::SURR_LAST) begin
                  job.data[2:0] = enc_w.data;
                  job.count_m1  = enc_w.len_m1;
                  emit          = 1'b1;
               end
            end
         end
         MODE_LATIN1: begin
            job.data[2:0] = enc_b.data;
            job.count_m1  = enc_b.len_m1;
            emit          = 1'b1;
         end
         default: begin
            mode_in = MODE_START;
            hv_in   = 1'b0;
         end
      endcase
      if (req_bus.str_last) begin
         mode_in = MODE_START;
         hv_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_START;
         hv_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         hv_ff   <= hv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hb_ff <= hb_in;
      end
   end

   `BTTU_ASSERT(a_front_last_restarts, clock, reset, (accept && req_bus.str_last) |=> (mode_ff == MODE_START && !hv_ff), "string end did not return the front end to the start mode")

endmodule

// File: sv/bttu_queue.sv
// Short job queue between the front end and the back end.
`include "assert_macros.svh"

module bttu_queue #(
   parameter int DEPTH = bttu_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  bttu_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output bttu_pkg::job_type pop_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bttu_pkg::job_type job_mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push_fire, pop_fire;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = job_mem_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         job_mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   `BTTU_ASSERT(a_queue_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue fill count exceeds its depth")
   `BTTU_ASSERT(a_queue_grow, clock, reset, (push_fire && !pop_fire) |=> (count_ff == $past(count_ff) + 1'b1), "queue fill count did not grow on a lone push")

endmodule

// File: sv/bttu_back.sv
// Back end: plays each job out as UTF-8 bytes, one beat per cycle while the result port is ready.
`include "assert_macros.svh"

module bttu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  bttu_pkg::job_type pop_job,
   bttu_rsp_if.source        rsp_bus
);

   bttu_pkg::job_type job_ff;
   logic              job_valid_ff;
   logic [1:0]        idx_ff;
   logic              at_end;

   assign at_end     = idx_ff == job_ff.count_m1;
   assign pop_ready  = !job_valid_ff || (rsp_bus.ready && at_end);

   assign rsp_bus.valid      = job_valid_ff;
   assign rsp_bus.utf8_byte  = job_ff.data[idx_ff];
   assign rsp_bus.run_last   = at_end;
   assign rsp_bus.string_end = at_end && job_ff.str_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (pop_ready) begin
         job_valid_ff <= pop_valid;
         idx_ff       <= '0;
      end else if (rsp_bus.ready) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready) begin
         job_ff <= pop_job;
      end
   end

   `BTTU_ASSERT(a_back_hold, clock, reset, (rsp_bus.valid && !rsp_bus.ready) |=> (job_valid_ff && $stable(idx_ff)), "byte index moved while the result beat was stalled")

endmodule

// File: sv/bom_text_to_utf8_transcoder.sv
// Top level of the byte-order-mark aware text to UTF-8 transcoder.
//
//   Channel   Direction   Beat
//   req_bus   in          one source byte, str_first, str_last
//   rsp_bus   out         one UTF-8 byte, run_last, string_end
//
// The front end takes one input beat per cycle while the job queue has room.
// The back end sends one UTF-8 byte per cycle while the result port is ready, so an input byte
// yields zero to four output bytes; the output port sets the sustained rate.
// A result passes through the queue memory and then the back end's job register before it appears.
// Reset is synchronous and clears the mode, the queue and the output stage.
// A stalled result port fills the queue, and then the input port stalls.
module bom_text_to_utf8_transcoder #(
   parameter int QUEUE_DEPTH = bttu_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   bttu_req_if.sink   req_bus,
   bttu_rsp_if.source rsp_bus
);

   logic              push_valid, push_ready;
   logic              pop_valid, pop_ready;
   bttu_pkg::job_type push_job, pop_job;

   bttu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   bttu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   bttu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp_bus   (rsp_bus)
   );

endmodule
